/* sv/fbrf_pkg.sv */
package fbrf_pkg;

  localparam int FB_WIDTH_DEF  = 240;
  localparam int FB_HEIGHT_DEF = 240;

  // coordinate width covers the largest store side plus one
  localparam int CW = 9;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_FILL = 2'd0,
    CMD_OPEN = 2'd1,
    CMD_COPY = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  // one clipped rectangle for the back end, x1 and y1 exclusive
  typedef struct packed {
    logic          is_read;
    logic          empty;
    logic [CW-1:0] x0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y0;
    logic [CW-1:0] y1;
    logic [15:0]   pixel;
  } rect_t;

endpackage

/* sv/fbrf_fifo.sv */
module fbrf_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/fbrf_front.sv */
module fbrf_front #(
  parameter int FB_WIDTH  = fbrf_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fbrf_pkg::FB_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic signed [9:0]  x,
  input  logic signed [9:0]  y,
  input  logic [8:0]         width,
  input  logic [8:0]         height,
  input  logic [15:0]        pixel,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output fbrf_pkg::rect_t    q_entry
);
  import fbrf_pkg::*;

  localparam logic signed [10:0] FBW_S = 11'(FB_WIDTH);
  localparam logic signed [10:0] FBH_S = 11'(FB_HEIGHT);

  logic signed [9:0] window_left;
  logic signed [9:0] window_top;
  logic [8:0]        window_width;
  logic [8:0]        window_height;
  logic [8:0]        window_column;
  logic [8:0]        window_row;
  logic              window_open;

  logic              accept;
  cmd_t              op;
  logic signed [10:0] xs, ys, xe, ye, x0s, y0s, x1s, y1s;
  logic signed [10:0] fx, fy;
  logic              fill_empty;
  logic              read_in;
  logic              copy_in;
  logic [8:0]        column_inc;
  logic [8:0]        row_inc;

  assign full   = q_full || clearing;
  assign accept = push && !full;
  assign op     = cmd_t'(cmd);

  always_comb begin
    xs  = 11'(x);
    ys  = 11'(y);
    xe  = xs + $signed({2'b00, width});
    ye  = ys + $signed({2'b00, height});
    x0s = (xs < 0) ? 11'sd0 : xs;
    y0s = (ys < 0) ? 11'sd0 : ys;
    x1s = (xe > FBW_S) ? FBW_S : xe;
    y1s = (ye > FBH_S) ? FBH_S : ye;
    fill_empty = (x1s <= x0s) || (y1s <= y0s);
    read_in = (xs >= 0) && (xs < FBW_S) && (ys >= 0) && (ys < FBH_S);
    fx = 11'(window_left) + $signed({2'b00, window_column});
    fy = 11'(window_top) + $signed({2'b00, window_row});
    copy_in = (fx >= 0) && (fx < FBW_S) && (fy >= 0) && (fy < FBH_S);
    column_inc = window_column + 1'b1;
    row_inc    = window_row + 1'b1;
  end

  always_comb begin
    q_push  = 1'b0;
    q_entry = '0;
    q_entry.pixel = pixel;
    unique case (op)
      CMD_FILL: begin
        q_push        = accept && !fill_empty;
        q_entry.x0    = x0s[8:0];
        q_entry.x1    = x1s[8:0];
        q_entry.y0    = y0s[8:0];
        q_entry.y1    = y1s[8:0];
      end
      CMD_OPEN: begin
        q_push = 1'b0;
      end
      CMD_COPY: begin
        q_push     = accept && window_open && copy_in;
        q_entry.x0 = fx[8:0];
        q_entry.x1 = fx[8:0] + 1'b1;
        q_entry.y0 = fy[8:0];
        q_entry.y1 = fy[8:0] + 1'b1;
      end
      CMD_READ: begin
        q_push          = accept;
        q_entry.is_read = 1'b1;
        q_entry.empty   = !read_in;
        q_entry.x0      = xs[8:0];
        q_entry.x1      = xs[8:0] + 1'b1;
        q_entry.y0      = ys[8:0];
        q_entry.y1      = ys[8:0] + 1'b1;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= '0;
      window_top    <= '0;
      window_width  <= '0;
      window_height <= '0;
      window_column <= '0;
      window_row    <= '0;
      window_open   <= 1'b0;
    end else if (accept) begin
      if (op == CMD_OPEN) begin
        window_left   <= x;
        window_top    <= y;
        window_width  <= width;
        window_height <= height;
        window_column <= '0;
        window_row    <= '0;
        window_open   <= (width != '0) && (height != '0);
      end else if (op == CMD_COPY && window_open) begin
        // position advances even when the pixel lands outside the store
        if (column_inc >= window_width) begin
          window_column <= '0;
          if (row_inc >= window_height) begin
            window_row  <= '0;
            window_open <= 1'b0;
          end else begin
            window_row <= row_inc;
          end
        end else begin
          window_column <= column_inc;
        end
      end
    end
  end

endmodule

/* sv/fbrf_back.sv */
module fbrf_back #(
  parameter int FB_WIDTH  = fbrf_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fbrf_pkg::FB_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  output logic            clearing,
  input  logic            q_empty,
  input  fbrf_pkg::rect_t q_entry,
  output logic            q_pop,
  input  logic            r_full,
  output logic            r_push,
  output logic [15:0]     r_data
);
  import fbrf_pkg::*;

  localparam int NPIX = FB_WIDTH * FB_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int SW   = (AW > CW) ? AW : CW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_RDWAIT
  } state_t;

  state_t        state;
  rect_t         cur;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [AW-1:0] row_base;
  logic [AW-1:0] clr_addr;
  logic [SW-1:0] addr_sum;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_re;
  logic [15:0]   mem_wdata;
  logic [15:0]   rd_data;
  logic [CW-1:0] col_inc;
  logic [CW-1:0] row_inc;
  logic          take_zero;

  logic [15:0]   mem [NPIX];

  assign clearing  = (state == ST_CLEAR);
  assign q_pop     = (state == ST_IDLE) && !q_empty && (!q_entry.is_read || !r_full);
  assign take_zero = q_pop && q_entry.is_read && q_entry.empty;
  assign r_push    = take_zero || (state == ST_RDWAIT);
  assign r_data    = (state == ST_RDWAIT) ? rd_data : 16'h0000;
  assign col_inc   = col + 1'b1;
  assign row_inc   = row + 1'b1;

  always_comb begin
    addr_sum  = SW'(row_base) + SW'(col);
    mem_addr  = clearing ? clr_addr : addr_sum[AW-1:0];
    mem_we    = clearing || (state == ST_WALK && !cur.is_read);
    mem_re    = (state == ST_WALK) && cur.is_read;
    mem_wdata = clearing ? 16'h0000 : cur.pixel;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(NPIX - 1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (q_pop) begin
            cur <= q_entry;
            if (!q_entry.empty) begin
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          row_base <= AW'(32'(cur.y0) * 32'(FB_WIDTH));
          col      <= cur.x0;
          row      <= cur.y0;
          state    <= ST_WALK;
        end
        ST_WALK: begin
          if (cur.is_read) begin
            state <= ST_RDWAIT;
          end else if (col_inc == cur.x1) begin
            col      <= cur.x0;
            row      <= row_inc;
            row_base <= row_base + AW'(FB_WIDTH);
            if (row_inc == cur.y1) begin
              state <= ST_IDLE;
            end
          end else begin
            col <= col_inc;
          end
        end
        ST_RDWAIT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/framebuffer_rect_fill_copy_top.sv */
// an in-store read passes the command queue, the back end's idle, setup, walk and read-wait
// states and the result queue; an off-store read goes to the result queue as it is popped
// in idle; fills and copies write their pixels in the walk state after idle and setup
// the back end takes no new command until the last is done; a 4-entry command queue
// decouples the two; reset: the store (FB_WIDTH*FB_HEIGHT pixels, 57600 by default) is
// swept to zero one pixel a cycle while full stays high
module framebuffer_rect_fill_copy_top #(
  parameter int FB_WIDTH  = fbrf_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fbrf_pkg::FB_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic signed [9:0] x,
  input  logic signed [9:0] y,
  input  logic [8:0]        width,
  input  logic [8:0]        height,
  input  logic [15:0]       pixel,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       read_pixel
);
  import fbrf_pkg::*;

  logic        clearing;
  logic        q_push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  rect_t       q_in;
  rect_t       q_out;
  logic        r_push;
  logic        r_full;
  logic [15:0] r_data;

  fbrf_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .x        (x),
    .y        (y),
    .width    (width),
    .height   (height),
    .pixel    (pixel),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  fbrf_fifo #(
    .W     ($bits(rect_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  fbrf_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_empty  (q_empty),
    .q_entry  (q_out),
    .q_pop    (q_pop),
    .r_full   (r_full),
    .r_push   (r_push),
    .r_data   (r_data)
  );

  fbrf_fifo #(
    .W     (16),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_data),
    .full  (r_full),
    .pop   (pop),
    .dout  (read_pixel),
    .empty (empty)
  );

`ifndef SYNTHESIS
  // the store sweep must hold off new transactions
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("transaction possible during store clear");

  a_reset_blocks: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  a_res_room: assert property (@(posedge clk) disable iff (rst) r_push |-> !r_full)
    else $error("result queue overflow");

  a_pop_room: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command queue popped while empty");
`endif

endmodule
